// ----- rtl/core/mts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mts_pkg;

  localparam int MTS_MAX_TYPES = 32;
  localparam int CNT_REG_W     = 6;
  localparam int FLAGS_W       = 5;
  localparam int HEAP_W        = 64;
  localparam int IDX_OUT_W     = 5;

  // property flag bits
  localparam int FLAG_DEVICE_LOCAL = 0;
  localparam int FLAG_HOST_VISIBLE = 1;
  localparam int FLAG_COHERENT     = 2;
  localparam int FLAG_CACHED       = 3;
  localparam int FLAG_LAZY         = 4;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // memory kinds
  localparam logic [2:0] KIND_OPAQUE    = 3'd0;
  localparam logic [2:0] KIND_LINEAR    = 3'd1;
  localparam logic [2:0] KIND_LAZY      = 3'd2;
  localparam logic [2:0] KIND_READ_MAP  = 3'd3;
  localparam logic [2:0] KIND_WRITE_MAP = 3'd4;

  typedef struct packed {
    logic               mode;
    logic [4:0]         entry_index;
    logic [FLAGS_W-1:0] entry_flags;
    logic [HEAP_W-1:0]  entry_heap_size;
    logic [31:0]        allowed_mask;
    logic [2:0]         kind;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] best_index;
  } out_item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0] flags;
    logic [HEAP_W-1:0]  heap;
  } entry_t;

  typedef struct packed {
    logic       en;
    logic [4:0] addr;
    entry_t     data;
  } tbl_wr_t;

  // true when candidate c should replace best b
  function automatic logic beats(input entry_t c, input entry_t b, input logic [2:0] kind,
                                 input logic mappable);
    logic res;
    if (kind == KIND_LAZY && c.flags[FLAG_LAZY] != b.flags[FLAG_LAZY]) begin
      res = c.flags[FLAG_LAZY];
    end else if (!mappable && c.flags[FLAG_DEVICE_LOCAL] != b.flags[FLAG_DEVICE_LOCAL]) begin
      res = c.flags[FLAG_DEVICE_LOCAL];
    end else if (kind == KIND_READ_MAP && c.flags[FLAG_CACHED] != b.flags[FLAG_CACHED]) begin
      res = c.flags[FLAG_CACHED];
    end else begin
      res = c.heap > b.heap;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mts_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mts_table import mts_pkg::*; #(
  parameter int MAX_TYPES = MTS_MAX_TYPES
) (
  input  wire logic    clk,
  input  wire tbl_wr_t wr,
  input  wire logic [((MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1)-1:0] rd_addr,
  output entry_t       rd_data
);

  localparam int IDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;

  entry_t mem [MAX_TYPES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[IDX_W-1:0]] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- rtl/core/mts_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mts_scan import mts_pkg::*; #(
  parameter int MAX_TYPES = MTS_MAX_TYPES
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  input  wire logic [$clog2(MAX_TYPES+1)-1:0] scan_len,
  output logic           busy,
  output tbl_wr_t        wr,
  output logic [((MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1)-1:0] rd_addr,
  input  wire entry_t    rd_data,
  output logic           out_strobe,
  output out_item_t      out_item
);

  localparam int IDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int CNT_W = $clog2(MAX_TYPES + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [IDX_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     len_r, len_nxt;
  logic [MAX_TYPES-1:0] mask_r, mask_nxt;
  logic [2:0]           kind_r, kind_nxt;
  logic                 map_r, map_nxt;
  logic                 pv_r, pv_nxt;
  logic [IDX_W-1:0]     pidx_r, pidx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  entry_t               best_r, best_nxt;
  logic                 strobe_r, strobe_nxt;
  out_item_t            res_r, res_nxt;

  logic accept, cand_ok, take, in_map;

  assign busy    = (state_r != ST_IDLE);
  assign accept  = start && !busy;
  assign rd_addr = cnt_r;
  assign in_map  = (in_item.kind == KIND_READ_MAP) || (in_item.kind == KIND_WRITE_MAP);

  always_comb begin
    wr.en   = accept && (in_item.mode == MODE_WRITE) &&
              ({1'b0, in_item.entry_index} < 6'(MAX_TYPES));
    wr.addr = in_item.entry_index;
    wr.data.flags = in_item.entry_flags;
    wr.data.heap  = in_item.entry_heap_size;
  end

  // candidate check on the entry read last cycle
  always_comb begin
    cand_ok = pv_r && mask_r[pidx_r] &&
              (!map_r || (rd_data.flags[FLAG_HOST_VISIBLE] && rd_data.flags[FLAG_COHERENT]));
    take    = cand_ok && (!found_r || beats(rd_data, best_r, kind_r, map_r));
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    mask_nxt     = mask_r;
    kind_nxt     = kind_r;
    map_nxt      = map_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = cnt_r;
    found_nxt    = found_r | cand_ok;
    best_idx_nxt = take ? pidx_r : best_idx_r;
    best_nxt     = take ? rd_data : best_r;
    strobe_nxt   = 1'b0;
    res_nxt      = res_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_item.mode == MODE_WRITE || scan_len == '0) begin
            strobe_nxt         = 1'b1;
            res_nxt.found      = 1'b0;
            res_nxt.best_index = '0;
          end else begin
            state_nxt = ST_SCAN;
            cnt_nxt   = '0;
            len_nxt   = scan_len;
            mask_nxt  = in_item.allowed_mask[MAX_TYPES-1:0];
            kind_nxt  = in_item.kind;
            map_nxt   = in_map;
            found_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        pv_nxt = 1'b1;
        if (CNT_W'(cnt_r) == len_r - CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt          = ST_IDLE;
        strobe_nxt         = 1'b1;
        res_nxt.found      = found_nxt;
        res_nxt.best_index = found_nxt ? IDX_OUT_W'(best_idx_nxt) : '0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pv_r     <= 1'b0;
      found_r  <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pv_r     <= pv_nxt;
      found_r  <= found_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    len_r      <= len_nxt;
    mask_r     <= mask_nxt;
    kind_r     <= kind_nxt;
    map_r      <= map_nxt;
    pidx_r     <= pidx_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule
`default_nettype wire

// ----- rtl/core/memory_type_selector_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// memory type selector: table of memory types and a best-type search
//
// input channel: an item is taken on a clock edge with start high and busy low
//   mode write: fills one table entry (flags and heap size); one result item
//     with found low follows in the next cycle, busy stays low
//   mode query: scans entries 0 .. n-1, one entry per cycle through
//     a registered table read and a single shared rank/compare unit
// query flow: n = min(type_count, MAX_TYPES); busy stays high through the
//   scan and a final drain state, so no new item is taken before the
//   query's result is shown; a query with n = 0 answers like a write
// result channel: out_strobe high for one cycle with out_item; the receiver
//   cannot stall, each result is shown exactly once
// config: cfg_we writes type_count from cfg_wdata; the user must do so only
//   while idle (not enforced); reset: type_count goes to zero and the
//   sequencer to idle; table contents are undefined until written
module memory_type_selector_unit import mts_pkg::*; #(
  parameter int MAX_TYPES = MTS_MAX_TYPES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_item,
  output logic                      out_strobe,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CNT_REG_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
  localparam int CNT_W = $clog2(MAX_TYPES + 1);

  logic [CNT_REG_W-1:0] type_count_r;
  logic [CNT_W-1:0]     scan_len;
  tbl_wr_t              tbl_wr;
  logic [IDX_W-1:0]     tbl_rd_addr;
  entry_t               tbl_rd_data;

  // type count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_count_r <= '0;
    end else if (cfg_we) begin
      type_count_r <= cfg_wdata;
    end
  end

  // a count past the table size scans the whole table
  assign scan_len = (type_count_r > CNT_REG_W'(MAX_TYPES)) ? CNT_W'(MAX_TYPES)
                                                          : CNT_W'(type_count_r);

  mts_table #(
    .MAX_TYPES(MAX_TYPES)
  ) u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data)
  );

  mts_scan #(
    .MAX_TYPES(MAX_TYPES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .scan_len  (scan_len),
    .busy      (busy),
    .wr        (tbl_wr),
    .rd_addr   (tbl_rd_addr),
    .rd_data   (tbl_rd_data),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ----- verif/memory_type_selector_unit_tb.sv -----
`timescale 1ns / 1ps
module memory_type_selector_unit_tb import mts_pkg::*;;

  // cycles with no item taken and no result shown before the run is declared hung
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles after the last result, well over a full-table query
  localparam int TAIL_CYCLES    = 80;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 start      = 1'b0;
  in_item_t             in_item    = '0;
  logic                 cfg_we     = 1'b0;
  logic [CNT_REG_W-1:0] cfg_wdata  = '0;
  logic                 busy;
  logic                 out_strobe;
  out_item_t            out_item;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  memory_type_selector_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // shadow of the block: memory type table and the entry count register
  // ---------------------------------------------------------------------------
  logic [FLAGS_W-1:0]   tbl_flags [MTS_MAX_TYPES];
  logic [HEAP_W-1:0]    tbl_heap  [MTS_MAX_TYPES];
  logic [CNT_REG_W-1:0] type_count_shadow = '0;

  // one expected result per accepted item, oldest first
  out_item_t expected_picks[$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  out_item_t want;

  // true when entry c should displace the current best entry b for this kind
  function automatic logic ranks_above(input int c, input int b, input logic [2:0] kind,
                                       input logic mappable);
    logic [FLAGS_W-1:0] fc;
    logic [FLAGS_W-1:0] fb;
    fc = tbl_flags[c];
    fb = tbl_flags[b];
    // lazy kind: lazily allocated memory ranks first
    if (kind == KIND_LAZY && fc[FLAG_LAZY] != fb[FLAG_LAZY]) return fc[FLAG_LAZY];
    // anything not mapped by the host prefers device local memory
    if (!mappable && fc[FLAG_DEVICE_LOCAL] != fb[FLAG_DEVICE_LOCAL])
      return fc[FLAG_DEVICE_LOCAL];
    // host reads want cached memory
    if (kind == KIND_READ_MAP && fc[FLAG_CACHED] != fb[FLAG_CACHED]) return fc[FLAG_CACHED];
    // last resort: strictly bigger heap, so ties keep the earlier entry
    return tbl_heap[c] > tbl_heap[b];
  endfunction

  // best memory type for a query against the current shadow table
  function automatic out_item_t predict_pick(input logic [31:0] mask, input logic [2:0] kind);
    out_item_t res;
    logic      mappable;
    logic      hit;
    int        n;
    int        best;
    res      = '0;
    hit      = 1'b0;
    best     = 0;
    mappable = (kind == KIND_READ_MAP) || (kind == KIND_WRITE_MAP);
    // counts above the table size scan the whole table only
    n = (type_count_shadow > MTS_MAX_TYPES) ? MTS_MAX_TYPES : int'(type_count_shadow);
    for (int i = 0; i < n; i++) begin
      if (mask[i] && (!mappable ||
                      (tbl_flags[i][FLAG_HOST_VISIBLE] && tbl_flags[i][FLAG_COHERENT]))) begin
        if (!hit) begin
          hit  = 1'b1;
          best = i;
        end else if (ranks_above(i, best, kind, mappable)) begin
          best = i;
        end
      end
    end
    if (hit) begin
      res.found      = 1'b1;
      res.best_index = best[IDX_OUT_W-1:0];
    end
    return res;
  endfunction

  // heap sizes: mostly values that tie or sit at the edges, some full-range
  function automatic logic [HEAP_W-1:0] pick_heap();
    logic [HEAP_W-1:0] h;
    case ($urandom_range(0, 4))
      0: h = {$urandom, $urandom};
      1: h = HEAP_W'($urandom_range(0, 3));
      2: h = '1;
      3: h = HEAP_W'(1) << $urandom_range(0, HEAP_W - 1);
      default: h = {$urandom, $urandom} >> $urandom_range(0, HEAP_W - 1);
    endcase
    return h;
  endfunction

  // random item, about half of them queries; fields a mode ignores stay random
  function automatic in_item_t random_item();
    in_item_t it;
    it.mode            = ($urandom_range(0, 1) == 0) ? MODE_WRITE : MODE_QUERY;
    it.entry_index     = 5'($urandom_range(0, MTS_MAX_TYPES - 1));
    it.entry_flags     = FLAGS_W'($urandom);
    it.entry_heap_size = pick_heap();
    // dense masks reach more candidates, sparse ones hit the empty case
    case ($urandom_range(0, 3))
      0:       it.allowed_mask = $urandom;
      1:       it.allowed_mask = $urandom & $urandom;
      2:       it.allowed_mask = $urandom | $urandom | $urandom;
      default: it.allowed_mask = '1;
    endcase
    // every kind including the undefined ones
    it.kind = 3'($urandom_range(0, 7));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one item and hold it until taken; start stays high for the caller
  task automatic send_item(input in_item_t it);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    // taken at this edge: update the shadow and queue the answer
    if (it.mode == MODE_WRITE) begin
      tbl_flags[it.entry_index] = it.entry_flags;
      tbl_heap[it.entry_index]  = it.entry_heap_size;
      expected_picks.push_back('0);
    end else begin
      expected_picks.push_back(predict_pick(it.allowed_mask, it.kind));
    end
  endtask

  task automatic write_entry(input int idx, input logic [FLAGS_W-1:0] flags,
                             input logic [HEAP_W-1:0] heap);
    in_item_t it;
    it                 = '0;
    it.mode            = MODE_WRITE;
    it.entry_index     = 5'(idx);
    it.entry_flags     = flags;
    it.entry_heap_size = heap;
    send_item(it);
  endtask

  task automatic query(input logic [31:0] mask, input logic [2:0] kind);
    in_item_t it;
    it              = '0;
    it.mode         = MODE_QUERY;
    it.allowed_mask = mask;
    it.kind         = kind;
    send_item(it);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every queued result has come back
  task automatic drain();
    start <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // the count register is only touched with the block idle
  task automatic set_type_count(input logic [CNT_REG_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    type_count_shadow = v;
  endtask

  // bursts of random length, random gaps, now and then a full drain
  task automatic run_traffic(input int n_items, input bit gaps_on);
    int burst_left;
    burst_left = $urandom_range(1, 12);
    for (int k = 0; k < n_items; k++) begin
      send_item(random_item());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        if ($urandom_range(0, 29) == 0) begin
          drain();
        end else if (gaps_on) begin
          pause(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // count is zero after reset: a query finds nothing
  task automatic test_empty_table();
    query('1, KIND_OPAQUE);
  endtask

  // small hand-built table that separates each ranking rule
  task automatic test_directed_ranking();
    logic [FLAGS_W-1:0] hv_coh;
    hv_coh = '0;
    hv_coh[FLAG_HOST_VISIBLE] = 1'b1;
    hv_coh[FLAG_COHERENT]     = 1'b1;
    write_entry(0, '0, '0);
    write_entry(1, FLAGS_W'(1) << FLAG_DEVICE_LOCAL, 64'd100);
    write_entry(2, hv_coh, 64'd200);
    // same heap as entry 2, cached: read mapping should prefer it
    write_entry(3, hv_coh | (FLAGS_W'(1) << FLAG_CACHED), 64'd200);
    write_entry(4, (FLAGS_W'(1) << FLAG_LAZY) | (FLAGS_W'(1) << FLAG_DEVICE_LOCAL), 64'd50);
    write_entry(5, '1, '1);
    // host visible but not coherent: never a mapping candidate
    write_entry(6, FLAGS_W'(1) << FLAG_HOST_VISIBLE, 64'hFFFF_FFFF_FFFF_FFFE);
    // device local tie with entry 1: earlier one stays
    write_entry(7, FLAGS_W'(1) << FLAG_DEVICE_LOCAL, 64'd100);
    // top index, outside the count for now
    write_entry(MTS_MAX_TYPES - 1, '1, '1);
    set_type_count(6'd8);
    // every kind, the undefined ones too, with every entry allowed
    for (int k = 0; k < 8; k++) query('1, 3'(k));
    query('0, KIND_OPAQUE);
    query(32'h0000_0040, KIND_WRITE_MAP);
    query(32'h0000_000C, KIND_READ_MAP);
    query(32'h0000_0082, KIND_LINEAR);
    query(32'h8000_0012, KIND_LAZY);
    query(32'h0000_0001, KIND_WRITE_MAP);
    pause(1);
  endtask

  // write every entry so that no query can read an unwritten one
  task automatic test_fill_table();
    in_item_t it;
    for (int i = 0; i < MTS_MAX_TYPES; i++) begin
      it             = random_item();
      it.mode        = MODE_WRITE;
      it.entry_index = 5'(i);
      send_item(it);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 4));
    end
  endtask

  // random traffic under several counts, the extremes among them
  task automatic test_random_phases();
    logic [CNT_REG_W-1:0] counts [7];
    counts[0] = 6'd32;
    counts[1] = 6'd1;
    counts[2] = 6'd63;
    counts[3] = 6'd33;
    counts[4] = 6'($urandom_range(2, 31));
    counts[5] = 6'd32;
    counts[6] = 6'($urandom_range(0, 63));
    for (int p = 0; p < 7; p++) begin
      set_type_count(counts[p]);
      // one phase runs back to back with no gaps
      run_traffic(60, p != 5);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking: one result per accepted item, in order
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_picks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: found %0b index %0d", out_item.found,
                   out_item.best_index);
      end else begin
        want = expected_picks.pop_front();
        if (out_item.found !== want.found || out_item.best_index !== want.best_index) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: found %0b index %0d, expected found %0b index %0d",
                     out_item.found, out_item.best_index, want.found, want.best_index);
        end
      end
    end
  end

  // hang detection: nothing taken and nothing returned for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_ranking();
    test_fill_table();
    test_random_phases();
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    // anything still queued here never came back
    mismatch_count += expected_picks.size();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
